// File: hw/rtl/bht_pkg.sv
package bht_pkg;

  localparam int FUNC_W = 2;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 64;

  // operation codes on the func field
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_DELETE,
    OP_NOP
  } op_t;

  // classified request as it travels through the queue
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic vld;
    req_t req;
  } q_head_t;

endpackage

// File: hw/rtl/bht_in_if.sv
interface bht_in_if import bht_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;

  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

// File: hw/rtl/bht_out_if.sv
interface bht_out_if import bht_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] found_value;
  logic             success;
  logic             full_res;

  modport source (output valid, found_value, success, full_res, input ready);
  modport sink   (input valid, found_value, success, full_res, output ready);
endinterface

// File: hw/rtl/bht_front.sv
module bht_front import bht_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  bht_in_if.sink  in_req,
  output logic    push,
  output req_t    push_req,
  input  logic    push_ready
);

  logic hold_vld_r;
  req_t hold_r;
  op_t  op_nxt;
  logic in_fire;

  always_comb begin
    unique case (in_req.func)
      FUNC_LOOKUP: op_nxt = OP_LOOKUP;
      FUNC_INSERT: op_nxt = OP_INSERT;
      FUNC_DELETE: op_nxt = OP_DELETE;
      default:     op_nxt = OP_NOP;
    endcase
  end

  assign in_req.ready = en && (!hold_vld_r || push_ready);
  assign in_fire      = in_req.valid && in_req.ready;
  assign push         = hold_vld_r;
  assign push_req     = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (in_fire) begin
      hold_vld_r <= 1'b1;
    end else if (push_ready) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_r.op    <= op_nxt;
      hold_r.key   <= in_req.key;
      hold_r.value <= in_req.value;
    end
  end

endmodule

// File: hw/rtl/bht_queue.sv
module bht_queue import bht_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  req_t    push_req,
  output logic    push_ready,
  output q_head_t head,
  input  logic    pop
);

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

  req_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && (cnt_r != '0);
  assign head.vld   = (cnt_r != '0);
  assign head.req   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// File: hw/rtl/bht_back.sv
module bht_back import bht_pkg::*; #(
  parameter int BUCKET_CNT        = 256,
  parameter int SLOTS_PER_SEGMENT = 4,
  parameter int MAX_SEGMENTS      = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  q_head_t  head,
  output logic     pop,
  output logic     clearing,
  bht_out_if.source out_res
);

  localparam int BKT_W  = (BUCKET_CNT > 1) ? $clog2(BUCKET_CNT) : 1;
  localparam int ROWS   = BUCKET_CNT * MAX_SEGMENTS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SLOT_W = (SLOTS_PER_SEGMENT > 1) ? $clog2(SLOTS_PER_SEGMENT) : 1;
  localparam int KROW_W = SLOTS_PER_SEGMENT * KEY_W;
  localparam int VROW_W = SLOTS_PER_SEGMENT * VAL_W;

  localparam logic [BKT_W-1:0]  BKT_MASK = BKT_W'(BUCKET_CNT - 1);
  localparam logic [SEG_W-1:0]  LAST_SEG = SEG_W'(MAX_SEGMENTS - 1);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } state_t;

  // one row holds one segment of a bucket
  logic [KROW_W-1:0] key_mem [ROWS];
  logic [VROW_W-1:0] val_mem [ROWS];
  logic [KROW_W-1:0] key_row_r;
  logic [VROW_W-1:0] val_row_r;

  state_t            state_r;
  logic [ROW_AW-1:0] clr_cnt_r;
  logic [SEG_W-1:0]  seg_r;
  req_t              item_r;
  logic              out_vld_r;
  logic [VAL_W-1:0]  found_r;
  logic              success_r;
  logic              full_r;

  logic [KEY_W-1:0]  slot_key [SLOTS_PER_SEGMENT];
  logic [VAL_W-1:0]  slot_val [SLOTS_PER_SEGMENT];
  logic [SLOTS_PER_SEGMENT-1:0] cand;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic [VAL_W-1:0]  hit_val;
  logic              dup;
  logic              finish;
  logic              start;
  logic              out_free;

  logic              rd_en;
  logic [KEY_W-1:0]  rd_key;
  logic [SEG_W-1:0]  rd_seg;
  logic [ROW_AW-1:0] rd_addr;
  logic              wr_en;
  logic [ROW_AW-1:0] wr_addr;
  logic [KROW_W-1:0] wr_key_row;
  logic [VROW_W-1:0] wr_val_row;

  logic [VAL_W-1:0]  res_found;
  logic              res_success;
  logic              res_full;

  function automatic logic [ROW_AW-1:0] row_of(input logic [KEY_W-1:0] k,
                                               input logic [SEG_W-1:0] s);
    logic [BKT_W-1:0] b;
    b = k[BKT_W-1:0] & BKT_MASK;
    return ROW_AW'(32'(b) * MAX_SEGMENTS + 32'(s));
  endfunction

  // slot compare across the row just read
  always_comb begin
    for (int i = 0; i < SLOTS_PER_SEGMENT; i++) begin
      slot_key[i] = key_row_r[i*KEY_W +: KEY_W];
      slot_val[i] = val_row_r[i*VAL_W +: VAL_W];
      if (item_r.op == OP_INSERT) begin
        cand[i] = (slot_val[i] == item_r.value) || (slot_val[i] == '0);
      end else begin
        cand[i] = (slot_key[i] == item_r.key);
      end
    end
  end

  // first candidate slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = SLOTS_PER_SEGMENT - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign hit_val  = val_row_r[hit_idx*VAL_W +: VAL_W];
  assign dup      = (hit_val == item_r.value);
  assign out_free = !out_vld_r || out_res.ready;
  assign start    = (state_r == S_IDLE) && head.vld && out_free;
  assign finish   = (state_r == S_SCAN) && (hit || (seg_r == LAST_SEG));
  assign pop      = start;
  assign clearing = (state_r == S_CLEAR);

  // read side: first row on start, next row while scanning
  assign rd_en   = (start && (head.req.op != OP_NOP)) || ((state_r == S_SCAN) && !finish);
  assign rd_key  = (state_r == S_IDLE) ? head.req.key : item_r.key;
  assign rd_seg  = (state_r == S_IDLE) ? '0 : seg_r + 1'b1;
  assign rd_addr = row_of(rd_key, rd_seg);

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = row_of(item_r.key, seg_r);
    wr_key_row = key_row_r;
    wr_val_row = val_row_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en      = 1'b1;
        wr_addr    = clr_cnt_r;
        wr_key_row = '0;
        wr_val_row = '0;
      end
      S_SCAN: begin
        if (item_r.op == OP_INSERT) begin
          wr_en = finish && hit && !dup;
          wr_key_row[hit_idx*KEY_W +: KEY_W] = item_r.key;
          wr_val_row[hit_idx*VAL_W +: VAL_W] = item_r.value;
        end else begin
          wr_en = finish && hit && (item_r.op == OP_DELETE);
          wr_key_row[hit_idx*KEY_W +: KEY_W] = '0;
          wr_val_row[hit_idx*VAL_W +: VAL_W] = '0;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_found   = '0;
    res_success = 1'b0;
    res_full    = 1'b0;
    unique case (item_r.op)
      OP_LOOKUP: begin
        res_found   = hit ? hit_val : '0;
        res_success = hit && (hit_val != '0);
      end
      OP_INSERT: begin
        res_success = hit && !dup;
        res_full    = !hit;
      end
      OP_DELETE: begin
        res_success = hit;
      end
      default: begin
        res_success = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key_row;
      val_mem[wr_addr] <= wr_val_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      key_row_r <= key_mem[rd_addr];
      val_row_r <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      seg_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_res.ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_ROW) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            item_r <= head.req;
            seg_r  <= '0;
            if (head.req.op == OP_NOP) begin
              out_vld_r <= 1'b1;
              found_r   <= '0;
              success_r <= 1'b0;
              full_r    <= 1'b0;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (finish) begin
            out_vld_r <= 1'b1;
            found_r   <= res_found;
            success_r <= res_success;
            full_r    <= res_full;
            state_r   <= S_IDLE;
          end else begin
            seg_r <= seg_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_res.valid       = out_vld_r;
  assign out_res.found_value = found_r;
  assign out_res.success     = success_r;
  assign out_res.full_res    = full_r;

endmodule

// File: hw/rtl/bucketized_hash_table.sv
// Bucketised hash table: 32-bit keys, 64-bit values (zero means empty).
// in_req  : one request per handshake; func selects lookup, insert or delete,
//           key picks the bucket through its low bits, value is used by insert.
// out_res : one result per request, in request order: found_value, success,
//           full_res.
// A front stage classifies each request and parks it in a two-entry queue;
// the back end scans the bucket one segment row per cycle from a row-wide
// memory (one read port, one write port, registered read data).
// The back end takes a new request only once it has finished the last one;
// an unused op code is answered without a scan. The scan stops at the first
// deciding slot.
// A request passes the front hold register and the queue, then the back end
// reads the bucket rows and writes the result register.
// Reset: a clearing pass writes all BUCKET_CNT * MAX_SEGMENTS rows to zero
// (1024 by default); in_req.ready stays low until it ends.
// Stall: results are held in the output register while out_res.ready is
// low; the back end starts no new request until that register frees, and
// the front keeps taking requests until the queue and its stage are full.
module bucketized_hash_table import bht_pkg::*; #(
  parameter int BUCKET_CNT        = 256,
  parameter int SLOTS_PER_SEGMENT = 4,
  parameter int MAX_SEGMENTS      = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  bht_in_if.sink    in_req,
  bht_out_if.source out_res
);

  logic    push;
  req_t    push_req;
  logic    push_ready;
  q_head_t head;
  logic    pop;
  logic    clearing;

  // front: accept and classify requests
  bht_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (!clearing),
    .in_req     (in_req),
    .push       (push),
    .push_req   (push_req),
    .push_ready (push_ready)
  );

  // decouples front and back
  bht_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_req   (push_req),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  // back: segment scan, slot update, result register
  bht_back #(
    .BUCKET_CNT        (BUCKET_CNT),
    .SLOTS_PER_SEGMENT (SLOTS_PER_SEGMENT),
    .MAX_SEGMENTS      (MAX_SEGMENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .out_res  (out_res)
  );

endmodule
